@@ rtl/bpcp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bpcp_pkg
// Constants and types shared by the bracketed pulse command parser.
// ---------------------------------------------------------------------------
package bpcp_pkg;

	localparam int unsigned MAX_BODY = 254;
	localparam int unsigned BODY_W = $clog2(MAX_BODY + 1);

	localparam logic [7:0] OPEN_CHAR  = 8'h5B;
	localparam logic [7:0] CLOSE_CHAR = 8'h5D;
	localparam logic [7:0] SPLIT_CHAR = 8'h2C;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] TAB_CHAR   = 8'h09;
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;

	localparam int unsigned ACC_W = 17;
	localparam logic [ACC_W-1:0] SAT_MAG = 17'd65536;
	localparam logic [ACC_W-1:0] MAX_PULSE = 17'd65535;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 40;

	// one result, fields listed from the highest bit down
	typedef struct packed {
		logic [5:0]  pad;
		logic        second_valid;
		logic [15:0] second_pulse;
		logic        first_valid;
		logic [15:0] first_pulse;
	} result_t;

endpackage : bpcp_pkg
`default_nettype wire

@@ rtl/bracketed_pulse_command_parser_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bracketed_pulse_command_parser_unit
// Parses "[a,b,...]" byte frames and gives the first two clamped token values.
// ---------------------------------------------------------------------------
//
// channel  dir  fields (lowest bit first)                         when
// s_*      in   tdata: received_byte[7:0]                         every byte
// m_*      out  tdata: first_pulse[15:0] first_valid              on ']' in frame
//                      second_pulse[15:0] second_valid, zero pad
//
// a byte is registered in the input stage; the parser state and the result
// register are updated from it when the input stage moves on. one byte per
// cycle is sustained while no result waits untaken. the input stage moves
// on whenever the result register is empty or being taken; while a result
// is held and not taken, the queued byte waits and s_tready drops. arst_n
// clears all control state and returns the parser to the outside-frame phase.
//
module bracketed_pulse_command_parser_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bpcp_pkg::IN_DATA_W-1:0]  s_tdata,   // received_byte[7:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [bpcp_pkg::OUT_DATA_W-1:0] m_tdata    // first_pulse, first_valid,
	                                                        // second_pulse, second_valid
);

	typedef enum logic [1:0] {
		FR_IDLE = 2'd0,
		FR_BODY = 2'd1,
		FR_NUL  = 2'd2
	} frame_t;

	typedef enum logic [1:0] {
		TK_START  = 2'd0,
		TK_SIGN   = 2'd1,
		TK_DIGITS = 2'd2,
		TK_DONE   = 2'd3
	} tok_t;

	// input stage
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       consume;

	// parser state
	frame_t                          frame_q, frame_d;
	tok_t                            tphase_q, tphase_d;
	logic                            nonempty_q, nonempty_d;
	logic                            neg_q, neg_d;
	logic [bpcp_pkg::ACC_W-1:0]      acc_q, acc_d;
	logic [1:0]                      tokens_q, tokens_d;
	logic [15:0]                     first_q, first_d;
	logic [bpcp_pkg::BODY_W-1:0]     blen_q, blen_d;

	// result register
	logic                            out_valid_q;
	bpcp_pkg::result_t               out_data_q;
	logic                            emit;
	bpcp_pkg::result_t               res_d;

	logic [bpcp_pkg::ACC_W-1:0]      clamp_v;
	logic [bpcp_pkg::ACC_W+3:0]      prod;
	logic                            is_digit, is_blank;

	assign consume  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || consume;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign is_digit = (byte_s1 >= bpcp_pkg::ZERO_CHAR) && (byte_s1 <= bpcp_pkg::NINE_CHAR);
	assign is_blank = (byte_s1 == bpcp_pkg::SPACE_CHAR)
		|| ((byte_s1 >= bpcp_pkg::TAB_CHAR) && (byte_s1 <= bpcp_pkg::CR_CHAR));
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (bpcp_pkg::ACC_W + 4)'(byte_s1 - bpcp_pkg::ZERO_CHAR);
	assign clamp_v = neg_q ? '0
		: ((acc_q > bpcp_pkg::MAX_PULSE) ? bpcp_pkg::MAX_PULSE : acc_q);

	always_comb begin
		frame_d    = frame_q;
		tphase_d   = tphase_q;
		nonempty_d = nonempty_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		tokens_d   = tokens_q;
		first_d    = first_q;
		blen_d     = blen_q;
		emit       = 1'b0;
		res_d      = '0;

		// the token-closing bytes (comma, nul, closing bracket) share this path
		if (frame_q != FR_IDLE && (byte_s1 == bpcp_pkg::CLOSE_CHAR
				|| (blen_q < (bpcp_pkg::BODY_W)'(bpcp_pkg::MAX_BODY) && frame_q == FR_BODY
				&& (byte_s1 == bpcp_pkg::SPLIT_CHAR || byte_s1 == bpcp_pkg::NUL_CHAR)))
				&& !(byte_s1 == bpcp_pkg::CLOSE_CHAR && frame_q != FR_BODY)) begin
			if (nonempty_q && tokens_q < 2'd2) begin
				if (tokens_q == 2'd0) begin
					first_d  = clamp_v[15:0];
					tokens_d = 2'd1;
				end else begin
					acc_d    = clamp_v;
					neg_d    = 1'b0;
					tokens_d = 2'd2;
				end
			end
			tphase_d   = TK_START;
			nonempty_d = 1'b0;
			if (tokens_d < 2'd2) begin
				acc_d = '0;
				neg_d = 1'b0;
			end
		end

		unique case (frame_q) inside
			FR_IDLE: begin
				if (byte_s1 == bpcp_pkg::OPEN_CHAR) begin
					frame_d    = FR_BODY;
					tphase_d   = TK_START;
					nonempty_d = 1'b0;
					neg_d      = 1'b0;
					acc_d      = '0;
					tokens_d   = 2'd0;
					first_d    = '0;
					blen_d     = '0;
				end
			end
			FR_BODY, FR_NUL: begin
				if (byte_s1 == bpcp_pkg::CLOSE_CHAR) begin
					emit               = 1'b1;
					res_d.first_valid  = (tokens_d != 2'd0);
					res_d.first_pulse  = (tokens_d != 2'd0) ? first_d : 16'd0;
					res_d.second_valid = (tokens_d == 2'd2);
					res_d.second_pulse = (tokens_d == 2'd2) ? acc_d[15:0] : 16'd0;
					frame_d    = FR_IDLE;
					tphase_d   = TK_START;
					nonempty_d = 1'b0;
					neg_d      = 1'b0;
					acc_d      = '0;
					tokens_d   = 2'd0;
					first_d    = '0;
					blen_d     = '0;
				end else if (blen_q < (bpcp_pkg::BODY_W)'(bpcp_pkg::MAX_BODY)) begin
					blen_d = blen_q + 1'b1;
					if (frame_q == FR_BODY) begin
						if (byte_s1 == bpcp_pkg::NUL_CHAR) begin
							frame_d = FR_NUL;
						end else if (byte_s1 != bpcp_pkg::SPLIT_CHAR) begin
							nonempty_d = 1'b1;
							if (tokens_q < 2'd2) begin
								if (is_digit && tphase_q != TK_DONE) begin
									tphase_d = TK_DIGITS;
									acc_d = (prod > (bpcp_pkg::ACC_W + 4)'(bpcp_pkg::SAT_MAG))
										? bpcp_pkg::SAT_MAG : prod[bpcp_pkg::ACC_W-1:0];
								end else if (tphase_q == TK_START && is_blank) begin
									tphase_d = TK_START;
								end else if (tphase_q == TK_START
										&& (byte_s1 == bpcp_pkg::PLUS_CHAR
										|| byte_s1 == bpcp_pkg::MINUS_CHAR)) begin
									tphase_d = TK_SIGN;
									neg_d    = (byte_s1 == bpcp_pkg::MINUS_CHAR);
								end else begin
									tphase_d = TK_DONE;
								end
							end
						end
					end
				end
			end
			default: begin
				frame_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			frame_q     <= FR_IDLE;
			tphase_q    <= TK_START;
			nonempty_q  <= 1'b0;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			tokens_q    <= 2'd0;
			first_q     <= '0;
			blen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (consume) begin
				frame_q    <= frame_d;
				tphase_q   <= tphase_d;
				nonempty_q <= nonempty_d;
				neg_q      <= neg_d;
				acc_q      <= acc_d;
				tokens_q   <= tokens_d;
				first_q    <= first_d;
				blen_q     <= blen_d;
			end
			if (consume && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (consume && emit) begin
			out_data_q <= res_d;
		end
	end

	a_pulse_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q.first_valid || out_data_q.first_pulse == 16'd0)
			&& (out_data_q.second_valid || out_data_q.second_pulse == 16'd0)))
		else $error("pulse value set without its valid flag");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.second_valid |-> out_data_q.first_valid)
		else $error("second token valid without first");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q == FR_IDLE |-> (blen_q == '0 && tokens_q == 2'd0))
		else $error("stale frame state outside a frame");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a queued byte");

endmodule : bracketed_pulse_command_parser_unit
`default_nettype wire
